@@ rtl/core/rau_pkg.sv @@
// Shared widths, operation codes and sequencer states of the rational arithmetic unit.
package rau_pkg;

   localparam int WORD_BITS = 32;
   localparam int PROD_BITS = 2 * WORD_BITS;
   localparam int SHIFT_BITS = 6;
   localparam int COUNT_BITS = 7;

   localparam logic [2:0] OP_ADD = 3'd0;
   localparam logic [2:0] OP_SUB = 3'd1;
   localparam logic [2:0] OP_MUL = 3'd2;
   localparam logic [2:0] OP_DIV = 3'd3;
   localparam logic [2:0] OP_CMP = 3'd4;

   localparam logic [1:0] ORD_LESS = 2'd0;
   localparam logic [1:0] ORD_EQUAL = 2'd1;
   localparam logic [1:0] ORD_GREATER = 2'd2;

   localparam logic [PROD_BITS-1:0] LIMIT = PROD_BITS'(1) << (WORD_BITS - 1);

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_MUL  = 7'b0000010,
      S_FORM = 7'b0000100,
      S_GCD  = 7'b0001000,
      S_DIVN = 7'b0010000,
      S_DIVD = 7'b0100000,
      S_DONE = 7'b1000000
   } state_type;

endpackage

@@ rtl/core/rau_gcd.sv @@
// Binary gcd of two nonzero 64-bit magnitudes, one subtract or shift per cycle.
module rau_gcd import rau_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [PROD_BITS-1:0] a_in,
   input  logic [PROD_BITS-1:0] b_in,
   output logic                 done,
   output logic [PROD_BITS-1:0] g
);

   logic [PROD_BITS-1:0]  a_ff, a_in_d, b_ff, b_in_d, g_ff, g_in;
   logic [SHIFT_BITS-1:0] k_ff, k_in;
   logic                  busy_ff, busy_in, done_ff, done_in;

   // Step: finish when either is zero, strip common twos, strip lone twos, else halve the difference
   always_comb begin
      a_in_d = a_ff;
      b_in_d = b_ff;
      k_in = k_ff;
      g_in = g_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in_d = a_in;
         b_in_d = b_in;
         k_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (a_ff == '0 || b_ff == '0) begin
            g_in = (a_ff | b_ff) << k_ff;
            busy_in = 1'b0;
            done_in = 1'b1;
         end else if (!a_ff[0] && !b_ff[0]) begin
            a_in_d = a_ff >> 1;
            b_in_d = b_ff >> 1;
            k_in = k_ff + SHIFT_BITS'(1);
         end else if (!a_ff[0]) begin
            a_in_d = a_ff >> 1;
         end else if (!b_ff[0]) begin
            b_in_d = b_ff >> 1;
         end else if (a_ff >= b_ff) begin
            a_in_d = (a_ff - b_ff) >> 1;
         end else begin
            b_in_d = (b_ff - a_ff) >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      a_ff <= a_in_d;
      b_ff <= b_in_d;
      k_ff <= k_in;
      g_ff <= g_in;
   end

   assign done = done_ff;
   assign g = g_ff;

endmodule

@@ rtl/core/rau_div.sv @@
// Restoring 64-bit divider, one quotient bit per cycle.
module rau_div import rau_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [PROD_BITS-1:0] dividend,
   input  logic [PROD_BITS-1:0] divisor,
   output logic                 done,
   output logic [PROD_BITS-1:0] quotient
);

   logic [PROD_BITS-1:0]  q_ff, q_in, rem_ff, rem_in, dvs_ff, dvs_in;
   logic [PROD_BITS:0]    trial;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic                  busy_ff, busy_in, done_ff, done_in;

   // Shift in one dividend bit, subtract when it fits
   always_comb begin
      trial = {rem_ff, q_ff[PROD_BITS-1]};
      q_in = q_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         q_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = PROD_BITS'(trial - {1'b0, dvs_ff});
            q_in = {q_ff[PROD_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial[PROD_BITS-1:0];
            q_in = {q_ff[PROD_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff + COUNT_BITS'(1);
         if (cnt_ff == COUNT_BITS'(PROD_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      q_ff <= q_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign quotient = q_ff;

endmodule

@@ rtl/core/rational_arith_unit_top.sv @@
// Top level of the rational arithmetic unit: sequencer, shared multiplier and result register.
// One word takes three products on the multiplier, a binary gcd and two divisions by
// the gcd; compare, zero results and invalid cases skip the gcd and the divisions and
// go from the products straight to the result register. The gcd loop and the
// one-bit-a-cycle divider dominate the time per word. req_stall is high while a word
// is in work; a finished result waits in the output register without holding off
// the next word.
module rational_arith_unit_top import rau_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [2:0]                  req_operation,
   input  logic signed [WORD_BITS-1:0] req_a_num,
   input  logic [WORD_BITS-2:0]        req_a_den,
   input  logic signed [WORD_BITS-1:0] req_b_num,
   input  logic [WORD_BITS-2:0]        req_b_den,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [WORD_BITS-1:0] rsp_res_num,
   output logic [WORD_BITS-2:0]        rsp_res_den,
   output logic                        rsp_res_valid,
   output logic [1:0]                  rsp_order
);

   state_type state_ff, state_in;
   logic [2:0]                  op_ff;
   logic signed [WORD_BITS:0]   an_ff, ad_ff, bn_ff, bd_ff;
   logic [1:0]                  step_ff, step_in;
   logic signed [WORD_BITS:0]   mul_a, mul_b;
   logic signed [2*WORD_BITS+1:0] prod;
   logic signed [PROD_BITS-1:0] p1_ff, p2_ff, p3_ff;
   logic signed [PROD_BITS-1:0] num_f;
   logic [PROD_BITS-1:0]        n_ff, n_in, d_ff, d_in;
   logic                        neg_ff, neg_in;
   logic signed [WORD_BITS-1:0] r_num_ff, r_num_in;
   logic [WORD_BITS-2:0]        r_den_ff, r_den_in;
   logic                        r_val_ff, r_val_in;
   logic [1:0]                  r_ord_ff, r_ord_in;
   logic                        out_v_ff;
   logic [WORD_BITS-1:0]        out_num_ff;
   logic [WORD_BITS-2:0]        out_den_ff;
   logic                        out_val_ff;
   logic [1:0]                  out_ord_ff;
   logic                        gcd_start, gcd_done, div_start, div_done;
   logic [PROD_BITS-1:0]        gcd_g, div_q;
   logic                        out_free;

   assign out_free = !out_v_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);

   // Select multiplier operands for each product step
   always_comb begin
      case (step_ff)
         2'd0: begin
            mul_a = an_ff;
            mul_b = (op_ff == OP_MUL) ? bn_ff : bd_ff;
         end
         2'd1: begin
            mul_a = ad_ff;
            mul_b = bn_ff;
         end
         default: begin
            mul_a = ad_ff;
            mul_b = (op_ff == OP_DIV) ? bn_ff : bd_ff;
         end
      endcase
      prod = mul_a * mul_b;
   end

   // Form the unreduced numerator
   always_comb begin
      case (op_ff)
         OP_ADD:  num_f = p1_ff + p2_ff;
         OP_SUB:  num_f = p1_ff - p2_ff;
         default: num_f = p1_ff;
      endcase
   end

   assign gcd_start = (state_ff == S_FORM) && (op_ff <= OP_DIV) && (p3_ff != '0)
                      && (num_f != '0);
   assign div_start = ((state_ff == S_GCD) && gcd_done) || ((state_ff == S_DIVN) && div_done);

   // Sequence one word through products and, where needed, gcd and divisions
   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      n_in = n_ff;
      d_in = d_ff;
      neg_in = neg_ff;
      r_num_in = r_num_ff;
      r_den_in = r_den_ff;
      r_val_in = r_val_ff;
      r_ord_in = r_ord_ff;
      unique case (state_ff)
         S_IDLE: begin
            step_in = '0;
            if (req_valid) state_in = S_MUL;
         end
         S_MUL: begin
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd2) state_in = S_FORM;
         end
         S_FORM: begin
            r_num_in = WORD_BITS'(1);
            r_den_in = '0;
            r_val_in = 1'b0;
            r_ord_in = ORD_LESS;
            neg_in = num_f[PROD_BITS-1] ^ p3_ff[PROD_BITS-1];
            n_in = num_f[PROD_BITS-1] ? PROD_BITS'(-num_f) : num_f;
            d_in = p3_ff[PROD_BITS-1] ? PROD_BITS'(-p3_ff) : p3_ff;
            state_in = S_DONE;
            if (op_ff == OP_CMP) begin
               r_num_in = '0;
               r_ord_in = (p1_ff < p2_ff) ? ORD_LESS :
                          (p1_ff == p2_ff) ? ORD_EQUAL : ORD_GREATER;
            end else if (op_ff <= OP_DIV && p3_ff != '0) begin
               if (num_f == '0) begin
                  r_num_in = '0;
                  r_den_in = (WORD_BITS-1)'(1);
                  r_val_in = 1'b1;
               end else begin
                  state_in = S_GCD;
               end
            end
         end
         S_GCD: begin
            if (gcd_done) state_in = S_DIVN;
         end
         S_DIVN: begin
            if (div_done) begin
               n_in = div_q;
               state_in = S_DIVD;
            end
         end
         S_DIVD: begin
            if (div_done) begin
               state_in = S_DONE;
               if (div_q > LIMIT - 1 || (neg_ff ? n_ff > LIMIT : n_ff > LIMIT - 1)) begin
                  r_num_in = WORD_BITS'(1);
                  r_den_in = '0;
                  r_val_in = 1'b0;
               end else begin
                  r_num_in = neg_ff ? WORD_BITS'(-n_ff) : WORD_BITS'(n_ff);
                  r_den_in = div_q[WORD_BITS-2:0];
                  r_val_in = 1'b1;
               end
               r_ord_in = ORD_LESS;
            end
         end
         S_DONE: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Registers: control with reset, payload without
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_DONE && out_free) out_v_ff <= 1'b1;
         else if (!rsp_stall) out_v_ff <= 1'b0;
      end
      if (state_ff == S_IDLE && req_valid) begin
         op_ff <= req_operation;
         an_ff <= {req_a_num[WORD_BITS-1], req_a_num};
         ad_ff <= {2'b00, req_a_den};
         bn_ff <= {req_b_num[WORD_BITS-1], req_b_num};
         bd_ff <= {2'b00, req_b_den};
      end
      if (state_ff == S_MUL) begin
         case (step_ff)
            2'd0:    p1_ff <= prod[PROD_BITS-1:0];
            2'd1:    p2_ff <= prod[PROD_BITS-1:0];
            default: p3_ff <= prod[PROD_BITS-1:0];
         endcase
      end
      if (state_ff == S_DONE && out_free) begin
         out_num_ff <= r_num_ff;
         out_den_ff <= r_den_ff;
         out_val_ff <= r_val_ff;
         out_ord_ff <= r_ord_ff;
      end
      step_ff <= step_in;
      n_ff <= n_in;
      d_ff <= d_in;
      neg_ff <= neg_in;
      r_num_ff <= r_num_in;
      r_den_ff <= r_den_in;
      r_val_ff <= r_val_in;
      r_ord_ff <= r_ord_in;
   end

   rau_gcd u_gcd (
      .clock (clock),
      .reset (reset),
      .start (gcd_start),
      .a_in  (num_f[PROD_BITS-1] ? PROD_BITS'(-num_f) : num_f),
      .b_in  (p3_ff[PROD_BITS-1] ? PROD_BITS'(-p3_ff) : p3_ff),
      .done  (gcd_done),
      .g     (gcd_g)
   );

   rau_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ((state_ff == S_GCD) ? n_ff : d_ff),
      .divisor  (gcd_g),
      .done     (div_done),
      .quotient (div_q)
   );

   assign rsp_valid = out_v_ff;
   assign rsp_res_num = out_num_ff;
   assign rsp_res_den = out_den_ff;
   assign rsp_res_valid = out_val_ff;
   assign rsp_order = out_ord_ff;

endmodule

@@ tb/sv/rational_arith_unit_top_tb.sv @@
// Self-checking testbench for the rational arithmetic unit: directed and random words.
`timescale 1ns / 100ps

module rational_arith_unit_top_tb import rau_pkg::*;;

   typedef struct packed {
      logic signed [31:0] num;
      logic [30:0]        den;
      logic               ok;
      logic [1:0]         ord;
   } rat_result_type;

   // Scoreboard: predicts each accepted word and checks results in order
   class rat_scoreboard;
      rat_result_type pending[$];
      int             mismatches;
      int             results_seen;

      function logic [63:0] gcd_u64(logic [63:0] a, logic [63:0] b);
         logic [63:0] t;
         while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
         end
         return a;
      endfunction

      function rat_result_type reduce_frac(longint num, longint den);
         rat_result_type r;
         logic [63:0] n, d, g, lim;
         bit neg;
         r = '{num: 1, den: 0, ok: 0, ord: ORD_LESS};
         lim = 64'd1 << 31;
         if (den == 0) return r;
         if (num == 0) return '{num: 0, den: 1, ok: 1, ord: ORD_LESS};
         neg = (num < 0) != (den < 0);
         n = num < 0 ? -num : num;
         d = den < 0 ? -den : den;
         g = gcd_u64(n, d);
         n = n / g;
         d = d / g;
         if (d > lim - 1 || (neg ? n > lim : n > lim - 1)) return r;
         r.num = neg ? -n[31:0] : n[31:0];
         r.den = d[30:0];
         r.ok = 1;
         return r;
      endfunction

      function void note_word(logic [2:0] op, logic signed [31:0] an, logic [30:0] ad,
                              logic signed [31:0] bn, logic [30:0] bd);
         longint x, y, pa, pb;
         rat_result_type r;
         pa = an; pb = bn;
         x = pa * longint'(bd);
         y = longint'(ad) * pb;
         r = '{num: 1, den: 0, ok: 0, ord: ORD_LESS};
         case (op)
            OP_ADD: r = reduce_frac(x + y, longint'(ad) * longint'(bd));
            OP_SUB: r = reduce_frac(x - y, longint'(ad) * longint'(bd));
            OP_MUL: r = reduce_frac(pa * pb, longint'(ad) * longint'(bd));
            OP_DIV: if (bn != 0) r = reduce_frac(x, y);
            OP_CMP: r = '{num: 0, den: 0, ok: 0,
                          ord: x < y ? ORD_LESS : (x == y ? ORD_EQUAL : ORD_GREATER)};
            default: ;
         endcase
         pending.push_back(r);
      endfunction

      function void check_word(rat_result_type got);
         rat_result_type exp_r;
         results_seen++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word %p", got);
            return;
         end
         exp_r = pending.pop_front();
         if (got !== exp_r) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected num %0d den %0d ok %0d ord %0d, got %0d %0d %0d %0d",
                        exp_r.num, exp_r.den, exp_r.ok, exp_r.ord,
                        got.num, got.den, got.ok, got.ord);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [2:0] req_operation = 0;
   logic signed [31:0] req_a_num = 0, req_b_num = 0;
   logic [30:0] req_a_den = 1, req_b_den = 1;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [31:0] rsp_res_num;
   logic [30:0] rsp_res_den;
   logic rsp_res_valid;
   logic [1:0] rsp_order;

   rat_scoreboard sb;
   int send_idle_pct, stall_pct;
   longint cycles = 0;
   int words_sent;

   always #1 clock = ~clock;

   rational_arith_unit_top u_top (.*);

   // Abort on runaway
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 1500000) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Check accepted result words and randomize the result stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_word('{num: rsp_res_num, den: rsp_res_den, ok: rsp_res_valid,
                         ord: rsp_order});
      rsp_stall <= !reset && ($urandom_range(99) < stall_pct);
   end

   // Send one word, with optional idle cycles first
   task automatic send_word(logic [2:0] op, logic signed [31:0] an, logic [30:0] ad,
                            logic signed [31:0] bn, logic [30:0] bd);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_operation <= op;
      req_a_num <= an; req_a_den <= ad;
      req_b_num <= bn; req_b_den <= bd;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_word(op, an, ad, bn, bd);
      words_sent++;
   endtask

   function automatic logic signed [31:0] rand_num();
      case ($urandom_range(5))
         0: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
         1: return 0;
         2: return $signed(32'($urandom_range(40))) - 20;
         3: return $signed(32'($urandom_range(2000))) - 1000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [30:0] rand_den();
      case ($urandom_range(4))
         0: return $urandom_range(1) ? 31'h7fffffff : 31'd1;
         1: return 31'($urandom_range(1, 30));
         2: return 31'($urandom_range(1, 3000));
         default: return 31'($urandom_range(1, 32'h7fffffff));
      endcase
   endfunction

   initial begin
      sb = new();
      send_idle_pct = 0;
      stall_pct = 0;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed words: field extremes, all operations, special cases
      send_word(OP_ADD, 1, 31'd2, 1, 31'd3);
      send_word(OP_SUB, 1, 31'd2, 1, 31'd2);
      send_word(OP_MUL, -3, 31'd4, 4, 31'd3);
      send_word(OP_DIV, 1, 31'd2, 0, 31'd5);
      send_word(OP_DIV, -7, 31'd3, 14, 31'd9);
      send_word(OP_CMP, 1, 31'd3, 1, 31'd3);
      send_word(OP_CMP, -1, 31'd3, 1, 31'd3);
      send_word(OP_CMP, 2, 31'd3, 1, 31'd3);
      send_word(OP_ADD, 32'sh7fffffff, 31'd1, 32'sh7fffffff, 31'd1);
      send_word(OP_MUL, 32'sh80000000, 31'd1, 32'sh80000000, 31'd1);
      send_word(OP_MUL, 32'sh80000000, 31'd1, 1, 31'd1);
      send_word(OP_DIV, 32'sh80000000, 31'd1, -1, 31'd1);
      send_word(OP_ADD, 1, 31'h7fffffff, 1, 31'h7ffffffe);
      send_word(OP_MUL, 1, 31'h7fffffff, 1, 31'h7fffffff);
      send_word(OP_ADD, 5, 31'd0, 3, 31'd7);
      send_word(OP_MUL, 0, 31'd0, 3, 31'd0);
      send_word(OP_CMP, 32'sh80000000, 31'h7fffffff, 32'sh7fffffff, 31'd0);
      send_word(3'd5, 1, 31'd1, 1, 31'd1);
      send_word(3'd6, -1, 31'h7fffffff, -1, 31'h7fffffff);
      send_word(3'd7, 32'sh7fffffff, 31'd1, 32'sh80000000, 31'd1);
      send_word(OP_SUB, 32'sh80000000, 31'h7fffffff, 32'sh7fffffff, 31'h7fffffff);

      // Random words across idle and stall phases
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 56; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 56; end
            default: begin send_idle_pct = 13; stall_pct = 13; end
         endcase
         repeat (135)
            send_word($urandom_range(9) == 0 ? 3'($urandom_range(7)) : 3'($urandom_range(4)),
                      rand_num(), $urandom_range(49) == 0 ? 31'd0 : rand_den(),
                      rand_num(), $urandom_range(49) == 0 ? 31'd0 : rand_den());
      end
      req_valid <= 0;
      stall_pct = 0;

      // Drain, then let the pipeline settle
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      $display("Sent %0d words over all five operations and four idle/stall mixes;",
               words_sent);
      $display("%0d result words checked, %0d mismatches.", sb.results_seen, sb.mismatches);
      if (sb.mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end
endmodule
